[design/cstu_pkg.sv]
// Package for the cosine/sine Taylor series unit.
// Holds fixed-point constants, datapath widths and the selector codes.
// No dependencies.
package cstu_pkg;

    localparam int DEF_SERIES_TERMS = 10;

    localparam int ANGLE_W = 32;
    localparam int VALUE_W = 32;
    localparam int MAG_W   = 33;
    localparam int X_W     = 26;
    localparam int X2_W    = 32;
    localparam int PC_W    = 33;
    localparam int PROD_W  = 66;
    localparam int N_W     = 37;
    localparam int NL_W    = 18;
    localparam int RCP_W   = N_W + 1;
    localparam int Q_W     = 36;
    localparam int P_W     = 38;

    localparam logic [MAG_W-1:0] TWO_PI_Q24  = 33'd105414357;
    localparam logic [MAG_W-1:0] PI_Q24      = 33'd52707179;
    localparam logic [33:0]      HALF_PI_Q24 = 34'd26353589;

    localparam logic signed [P_W-1:0] ONE_Q30 = 38'sd1073741824;
    localparam logic signed [P_W-1:0] P_LIMIT = 38'sd2147483648;

    typedef enum logic {
        CMD_COS = 1'b0,
        CMD_SIN = 1'b1
    } cmd_t;

endpackage

[design/cosine_sine_taylor_unit.sv]
// Top level of the cosine/sine Taylor series unit: range reduction and a
// fully pipelined Horner evaluation of the even series.
// Depends on cstu_pkg.
//
// Usage:
//   Slave channel: s_tdata carries the angle (signed Q7.24), s_tuser selects
//   cosine (0) or sine (1). A beat is taken when s_tvalid and s_tready are high.
//   Master channel: m_tdata carries the result, signed Q1.30, clipped to +/-1.0.
//   Stages from input beat to output beat: six stages do the offset, absolute
//   value, modulo 2*pi by restoring subtraction, the pi fold and x squared;
//   each series term takes four stages (product, rounding, reciprocal partial
//   products, sum and Horner update); one stage applies the sign and clips.
//   Throughput: one beat per cycle while the receiver takes results.
//   Reset (aresetn low, synchronous) clears all stage valid flags; no clearing
//   pass is needed.
//   Stall: while m_tvalid is high and m_tready low the whole pipeline holds and
//   s_tready is low; no beat is lost or repeated.
module cosine_sine_taylor_unit
    import cstu_pkg::*;
#(
    parameter int SERIES_TERMS = DEF_SERIES_TERMS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [ANGLE_W-1:0] s_tdata,   // [31:0] angle
    input  logic               s_tuser,   // [0] cmd
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] m_tdata    // [31:0] value
);

    localparam int TB    = 6;
    localparam int DEPTH = 7 + 4 * SERIES_TERMS;

    logic             adv;
    logic [DEPTH-1:0] vld_reg;

    assign adv      = !(vld_reg[DEPTH-1] && !m_tready);
    assign s_tready = adv;
    assign m_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // range reduction
    logic signed [33:0] a_reg, a_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [MAG_W-1:0]   red1_reg, red1_next;
    logic [MAG_W-1:0]   red2_reg, red2_next;
    logic [X_W-1:0]     x_reg, x_next;
    logic               neg0_reg, neg0_next;
    logic               neg1_reg;
    logic [X2_W-1:0]    x2_reg, x2_next;
    logic [51:0]        sq;
    logic [MAG_W-1:0]   r0, r1, r2, r3, r4;

    always_comb begin
        a_next = {{2{s_tdata[ANGLE_W-1]}}, s_tdata};
        if (cmd_t'(s_tuser) == CMD_SIN) begin
            a_next = a_next - $signed(HALF_PI_Q24);
        end
        mag_next = a_reg[33] ? MAG_W'(-a_reg) : MAG_W'(a_reg);

        r0 = mag_reg;
        if (r0 >= (TWO_PI_Q24 << 4)) r0 = r0 - (TWO_PI_Q24 << 4);
        r1 = r0;
        if (r1 >= (TWO_PI_Q24 << 3)) r1 = r1 - (TWO_PI_Q24 << 3);
        red1_next = r1;

        r2 = red1_reg;
        if (r2 >= (TWO_PI_Q24 << 2)) r2 = r2 - (TWO_PI_Q24 << 2);
        r3 = r2;
        if (r3 >= (TWO_PI_Q24 << 1)) r3 = r3 - (TWO_PI_Q24 << 1);
        red2_next = r3;

        r4 = red2_reg;
        if (r4 >= TWO_PI_Q24) r4 = r4 - TWO_PI_Q24;
        if (r4 > PI_Q24) begin
            x_next    = X_W'(r4 - PI_Q24);
            neg0_next = 1'b1;
        end else begin
            x_next    = X_W'(r4);
            neg0_next = 1'b0;
        end

        sq      = x_reg * x_reg;
        x2_next = X2_W'((53'(sq) + 53'd524288) >> 20);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg    <= a_next;
            mag_reg  <= mag_next;
            red1_reg <= red1_next;
            red2_reg <= red2_next;
            x_reg    <= x_next;
            neg0_reg <= neg0_next;
            x2_reg   <= x2_next;
            neg1_reg <= neg0_reg;
        end
    end

    // Horner terms, four stages each
    logic signed [PROD_W-1:0] prod_reg [SERIES_TERMS];
    logic [N_W-1:0]           n_reg    [SERIES_TERMS];
    logic [56:0]              ph_reg   [SERIES_TERMS];
    logic [55:0]              pl_reg   [SERIES_TERMS];
    logic signed [P_W-1:0]    p_reg    [SERIES_TERMS];
    logic                     sgnb_reg [SERIES_TERMS];
    logic                     sgnc_reg [SERIES_TERMS];
    logic [X2_W-1:0]          x2a_reg  [SERIES_TERMS];
    logic [X2_W-1:0]          x2b_reg  [SERIES_TERMS];
    logic [X2_W-1:0]          x2c_reg  [SERIES_TERMS];
    logic [X2_W-1:0]          x2d_reg  [SERIES_TERMS];
    logic                     nega_reg [SERIES_TERMS];
    logic                     negb_reg [SERIES_TERMS];
    logic                     negc_reg [SERIES_TERMS];
    logic                     negd_reg [SERIES_TERMS];

    for (genvar t = 0; t < SERIES_TERMS; t++) begin : g_term
        localparam int K   = SERIES_TERMS - t;
        localparam int C   = (2 * K - 1) * (2 * K);
        localparam int L   = $clog2(C);
        localparam int SH  = N_W + L;
        localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(C) - 64'd1) / 64'(C);
        localparam logic [64:0] RND   = 65'(C) << 27;

        logic signed [P_W-1:0]    p_src;
        logic [X2_W-1:0]          x2_src;
        logic                     neg_src;
        logic signed [P_W-1:0]    p_sat;
        logic signed [PC_W-1:0]   pc;
        logic signed [PROD_W-1:0] prod_next;
        logic [63:0]              pmag;
        logic [N_W-1:0]           n_next;
        logic [56:0]              ph_next;
        logic [55:0]              pl_next;
        logic [75:0]              sum;
        logic [Q_W-1:0]           q;
        logic signed [P_W-1:0]    qs;
        logic signed [P_W-1:0]    p_next;

        if (t == 0) begin : g_first
            assign p_src   = ONE_Q30;
            assign x2_src  = x2_reg;
            assign neg_src = neg1_reg;
        end else begin : g_next
            assign p_src   = p_reg[t-1];
            assign x2_src  = x2d_reg[t-1];
            assign neg_src = negd_reg[t-1];
        end

        always_comb begin
            if (p_src > P_LIMIT) begin
                p_sat = P_LIMIT;
            end else if (p_src < -P_LIMIT) begin
                p_sat = -P_LIMIT;
            end else begin
                p_sat = p_src;
            end
            pc        = PC_W'(p_sat);
            prod_next = $signed({1'b0, x2_src}) * pc;

            pmag   = prod_reg[t][PROD_W-1] ? 64'(-prod_reg[t]) : 64'(prod_reg[t]);
            n_next = N_W'((65'(pmag) + RND) >> 28);

            ph_next = n_reg[t][N_W-1:NL_W] * RECIP[RCP_W-1:0];
            pl_next = n_reg[t][NL_W-1:0] * RECIP[RCP_W-1:0];

            sum    = {1'b0, ph_reg[t], 18'b0} + 76'(pl_reg[t]);
            q      = Q_W'(sum >> SH);
            qs     = sgnc_reg[t] ? -$signed(P_W'(q)) : $signed(P_W'(q));
            p_next = ONE_Q30 - qs;
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                prod_reg[t] <= prod_next;
                x2a_reg[t]  <= x2_src;
                nega_reg[t] <= neg_src;

                n_reg[t]    <= n_next;
                sgnb_reg[t] <= prod_reg[t][PROD_W-1];
                x2b_reg[t]  <= x2a_reg[t];
                negb_reg[t] <= nega_reg[t];

                ph_reg[t]   <= ph_next;
                pl_reg[t]   <= pl_next;
                sgnc_reg[t] <= sgnb_reg[t];
                x2c_reg[t]  <= x2b_reg[t];
                negc_reg[t] <= negb_reg[t];

                p_reg[t]    <= p_next;
                x2d_reg[t]  <= x2c_reg[t];
                negd_reg[t] <= negc_reg[t];
            end
        end
    end

    // sign and clip
    logic signed [P_W-1:0]     v;
    logic [VALUE_W-1:0]        m_tdata_reg, m_tdata_next;

    always_comb begin
        v = negd_reg[SERIES_TERMS-1] ? -p_reg[SERIES_TERMS-1] : p_reg[SERIES_TERMS-1];
        if (v > ONE_Q30) begin
            m_tdata_next = VALUE_W'(ONE_Q30);
        end else if (v < -ONE_Q30) begin
            m_tdata_next = VALUE_W'(-ONE_Q30);
        end else begin
            m_tdata_next = VALUE_W'(v);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tdata = m_tdata_reg;

    a_in_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");

    a_mod_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] |-> (red2_reg < (TWO_PI_Q24 << 1)))
        else $error("modulo reduction left too large a remainder");

    a_fold_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[4] |-> (MAG_W'(x_reg) <= PI_Q24))
        else $error("folded angle above pi");

    a_first_term: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[TB+3] |-> ((p_reg[0] <= P_LIMIT) && (p_reg[0] >= -P_LIMIT)))
        else $error("first Horner term out of range");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(m_tdata) <= 32'sd1073741824)
                   && ($signed(m_tdata) >= -32'sd1073741824)))
        else $error("result beyond plus or minus one");

endmodule

[dv/tb_top.sv]
// Testbench for cosine_sine_taylor_unit: drives angles with a cosine/sine
// selector and checks each result against an in-bench Taylor series predictor.
// Depends on cstu_pkg and the RTL of the unit.
module tb_top;
    import cstu_pkg::*;

    localparam int  WATCHDOG  = 20000;
    localparam int  DRAIN     = 120;
    localparam longint TWO_PI = 105414357;
    localparam longint PI     = 52707179;
    localparam longint HALF_PI = 26353589;
    localparam longint ONE    = 1073741824;
    localparam longint PLIM   = 64'sd2147483648;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [ANGLE_W-1:0] s_tdata = '0;
    logic               s_tuser = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [VALUE_W-1:0] m_tdata;

    logic [VALUE_W-1:0] expected_values[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  timed_out = 1'b0;
    bit  quiet = 1'b0;
    bit  hold_off = 1'b0;

    cosine_sine_taylor_unit dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic [VALUE_W-1:0] taylor_cos_sin(cmd_t sel, logic [ANGLE_W-1:0] ang);
        longint a;
        longint x;
        longint x2;
        longint p;
        longint d;
        bit     flip;
        a = longint'($signed(ang));
        flip = 1'b0;
        if (sel == CMD_SIN)
            a -= HALF_PI;
        x = a % TWO_PI;
        if (x < 0)
            x = -x;
        if (x > PI) begin
            x -= PI;
            flip = 1'b1;
        end
        x2 = (x * x + (longint'(1) << 19)) >>> 20;
        p = ONE;
        for (int k = DEF_SERIES_TERMS; k >= 1; k--) begin
            d = longint'((2 * k - 1) * (2 * k)) * (longint'(1) << 28);
            if (p > PLIM) p = PLIM;
            if (p < -PLIM) p = -PLIM;
            p = ONE - round_div(x2 * p, d);
        end
        if (flip)
            p = -p;
        if (p > ONE) p = ONE;
        if (p < -ONE) p = -ONE;
        return p[31:0];
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_values.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %h", m_tdata);
            end else begin
                logic [VALUE_W-1:0] want;
                want = expected_values.pop_front();
                if (m_tdata !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("value mismatch: expected %0d got %0d",
                                 $signed(want), $signed(m_tdata));
                end
            end
        end
    end

    // receiver backpressure
    always @(negedge aclk) begin
        if (hold_off || !aresetn)
            m_tready <= 1'b0;
        else if (quiet)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 31);
    end

    // watchdog on accepted beats
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (aresetn)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // s_tvalid stays high after a beat until the next call drops it or
    // replaces the beat
    task automatic send_angle(cmd_t sel, logic [ANGLE_W-1:0] ang);
        if (!quiet) begin
            while ($urandom_range(99) < 31) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ang;
        s_tuser  <= sel;
        do @(posedge aclk); while (!s_tready);
        expected_values.push_back(taylor_cos_sin(sel, ang));
        @(negedge aclk);
    endtask

    task automatic test_extremes();
        logic [ANGLE_W-1:0] corners[12];
        corners = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                    32'h0000_0001, 32'(PI), 32'(PI + 1), 32'(-PI),
                    32'(TWO_PI), 32'(-TWO_PI), 32'(HALF_PI), 32'(PI + HALF_PI)};
        foreach (corners[i]) begin
            send_angle(CMD_COS, corners[i]);
            send_angle(CMD_SIN, corners[i]);
        end
    endtask

    task automatic test_random_angles(int n);
        logic [ANGLE_W-1:0] ang;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(2))
                0: ang = $urandom();
                1: ang = 32'($signed($urandom_range(2 * 105414357)) - 105414357);
                default: ang = 32'($signed($urandom_range(40)) - 20) * 32'(HALF_PI)
                               + 32'($signed($urandom_range(4)) - 2);
            endcase
            send_angle(cmd_t'($urandom_range(1)), ang);
        end
    endtask

    task automatic test_no_idle(int n);
        quiet = 1'b1;
        test_random_angles(n);
        quiet = 1'b0;
    endtask

    task automatic test_output_stall();
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(negedge aclk);
                hold_off = 1'b0;
            end
            test_random_angles(120);
        join
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_extremes();
        test_random_angles(500);
        test_no_idle(300);
        test_output_stall();
        test_random_angles(250);
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0)
            @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
        if (mismatches == 0 && expected_values.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

[files.f]
design/cstu_pkg.sv
design/cosine_sine_taylor_unit.sv
dv/tb_top.sv
